### hw/rtl/bfp_pkg.sv
// shared types and codes for the bit field packer
package bfp_pkg;

	localparam int BUFFER_BYTES_DEF = 2048;

	// configuration port
	localparam int ADDR_W = 3;
	localparam int LIMIT_W = 12;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2048;

	typedef logic [ADDR_W-3:0] reg_idx_t;
	localparam reg_idx_t REG_READ_LIMIT = reg_idx_t'(0);
	localparam reg_idx_t REG_WRITE_LIMIT = reg_idx_t'(1);

	typedef logic [2:0] action_t;
	localparam action_t ACT_WRITE_U = 3'd0;
	localparam action_t ACT_READ_U = 3'd1;
	localparam action_t ACT_WRITE_S = 3'd2;
	localparam action_t ACT_READ_S = 3'd3;
	localparam action_t ACT_SEEK = 3'd4;
	localparam action_t ACT_RESTART = 3'd5;

	localparam logic [5:0] MAX_FIELD = 6'd32;

endpackage

### hw/rtl/bfp_bank.sv
// one byte-wide bank of the packer buffer, registered read
module bfp_bank #(
	parameter int DEPTH = 258,
	parameter int AW = 9
) (
	input  logic          clk,
	input  logic          re,
	input  logic [AW-1:0] ra,
	output logic [7:0]    rd,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  logic [7:0]    wd
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		// old data on a same-address collision, the caller forwards
		if (re) begin
			rd <= mem[ra];
		end
	end

endmodule

### hw/rtl/bit_field_packer.sv
// top level of the bit field packer: cursor, banked buffer, two-stage read-modify-write
// an accepted beat enters the stage 1 registers, then the output register once the output is free
// throughput: one item per cycle unless clearing or stalled, read-modify-write over stages 0 and 1
// a write in stage 1 is forwarded to the read of the next item on the same bank entry
// reset: cursor and error clear, limits return to 2048 at once; then a clearing pass over all
// BUFFER_BYTES/8+2 entries zeroes the eight banks while in_ready stays low (258 at 2048 bytes)
module bit_field_packer #(
	parameter int BUFFER_BYTES = bfp_pkg::BUFFER_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bfp_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  bfp_pkg::action_t            action,
	input  logic signed [31:0]          write_value,
	input  logic [5:0]                  bit_count,
	input  logic [11:0]                 seek_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [31:0]          read_data,
	output logic [14:0]                 bit_position,
	output logic [11:0]                 byte_position,
	output logic                        access_failed,
	output logic                        sticky_error
);

	import bfp_pkg::*;

	localparam int BW = $clog2(BUFFER_BYTES + 1);
	localparam int CW = BW + 3;
	localparam int NB = 8;
	localparam int NE = BUFFER_BYTES / 8 + 2;
	localparam int AW = $clog2(NE);

	// configuration registers
	logic [LIMIT_W-1:0] read_limit_q, write_limit_q;
	reg_idx_t           cfg_idx;

	assign pready = 1'b1;
	assign cfg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_limit_q <= LIMIT_RESET;
			write_limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (cfg_idx)
				REG_READ_LIMIT: read_limit_q <= pwdata[LIMIT_W-1:0];
				REG_WRITE_LIMIT: write_limit_q <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_READ_LIMIT: prdata = 32'(read_limit_q);
			REG_WRITE_LIMIT: prdata = 32'(write_limit_q);
			default: prdata = '0;
		endcase
	end

	// clearing pass
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(NE - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// pipeline control
	logic valid_s1, s1_adv, accept;

	assign s1_adv = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !clr_busy_q && (!valid_s1 || s1_adv);
	assign accept = in_valid && in_ready;

	// stage 0: limits, decode, cursor update
	logic [CW-1:0] cursor_q;
	logic          err_q;
	logic [BW-1:0] rlim_c, wlim_c, seek_c;
	logic [CW-1:0] lim_sel;
	logic [CW:0]   sum1, sumc, sumw;
	logic          fit1, fitc, fitw;
	logic [5:0]    cnt, cnt1;
	logic [31:0]   mag;
	logic          neg;

	logic          wr0, rd0, sgn0, fail0, err_n;
	logic [5:0]    w0;
	logic [31:0]   fv0, mask0;
	logic [CW-1:0] cur_n;
	logic [AW-1:0] addr0 [NB];

	assign rlim_c = (32'(read_limit_q) > 32'(BUFFER_BYTES)) ? BW'(BUFFER_BYTES)
		: BW'(read_limit_q);
	assign wlim_c = (32'(write_limit_q) > 32'(BUFFER_BYTES)) ? BW'(BUFFER_BYTES)
		: BW'(write_limit_q);
	assign seek_c = (32'(seek_byte) > 32'(BUFFER_BYTES)) ? BW'(BUFFER_BYTES)
		: BW'(seek_byte);

	assign lim_sel = (action == ACT_WRITE_U || action == ACT_WRITE_S) ? {wlim_c, 3'b000}
		: {rlim_c, 3'b000};

	assign cnt = (bit_count > MAX_FIELD) ? MAX_FIELD : bit_count;
	assign cnt1 = (cnt == 6'd0) ? 6'd1 : cnt;

	assign sum1 = {1'b0, cursor_q} + (CW+1)'(1);
	assign sumc = {1'b0, cursor_q} + (CW+1)'(cnt);
	assign sumw = {1'b0, cursor_q} + (CW+1)'(cnt1);
	assign fit1 = sum1 <= {1'b0, lim_sel};
	assign fitc = sumc <= {1'b0, lim_sel};
	assign fitw = sumw <= {1'b0, lim_sel};

	assign neg = write_value[31];
	assign mag = neg ? (32'd0 - write_value) : write_value;

	always_comb begin
		wr0 = 1'b0;
		rd0 = 1'b0;
		sgn0 = 1'b0;
		fail0 = 1'b0;
		w0 = 6'd0;
		fv0 = write_value;
		cur_n = cursor_q;
		err_n = err_q;
		unique case (action)
			ACT_WRITE_U, ACT_READ_U: begin
				wr0 = (action == ACT_WRITE_U);
				rd0 = (action == ACT_READ_U);
				if (cnt != 6'd0) begin
					if (fitc) begin
						w0 = cnt;
					end else begin
						fail0 = 1'b1;
					end
				end
			end
			ACT_WRITE_S, ACT_READ_S: begin
				wr0 = (action == ACT_WRITE_S);
				rd0 = (action == ACT_READ_S);
				sgn0 = 1'b1;
				// flag in bit 0, magnitude above it
				fv0 = {mag[30:0], neg};
				if (fit1) begin
					if (cnt <= 6'd1 || fitw) begin
						w0 = cnt1;
					end else begin
						w0 = 6'd1;
						fail0 = 1'b1;
					end
				end else begin
					fail0 = 1'b1;
				end
			end
			ACT_SEEK: cur_n = {seek_c, 3'b000};
			ACT_RESTART: begin
				cur_n = '0;
				err_n = 1'b0;
			end
			default: ;
		endcase
		if (wr0 || rd0) begin
			cur_n = cursor_q + CW'(w0);
			if (fail0) begin
				err_n = 1'b1;
			end
		end
	end

	assign mask0 = (w0 == MAX_FIELD) ? '1 : ((32'd1 << w0) - 32'd1);

	// bank k holds bytes whose index is k mod 8
	always_comb begin
		for (int k = 0; k < NB; k++) begin
			addr0[k] = AW'(cursor_q[CW-1:6]) + AW'(3'(k) < cursor_q[5:3]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			err_q <= 1'b0;
		end else if (accept) begin
			cursor_q <= cur_n;
			err_q <= err_n;
		end
	end

	// stage 1 registers
	logic          wr_s1, rd_s1, sgn_s1, fail_s1, err_s1;
	logic [5:0]    w_s1;
	logic [2:0]    off_s1, base3_s1;
	logic [31:0]   fv_s1, mask_s1;
	logic [CW-1:0] cur_s1;
	logic [AW-1:0] addr_s1 [NB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_s1 <= wr0;
			rd_s1 <= rd0;
			sgn_s1 <= sgn0;
			fail_s1 <= fail0;
			err_s1 <= err_n;
			w_s1 <= w0;
			off_s1 <= cursor_q[2:0];
			base3_s1 <= cursor_q[5:3];
			fv_s1 <= fv0;
			mask_s1 <= mask0;
			cur_s1 <= cur_n;
			for (int k = 0; k < NB; k++) begin
				addr_s1[k] <= addr0[k];
			end
		end
	end

	// banks
	logic [7:0]    bank_rd [NB];
	logic          bwe [NB];
	logic [AW-1:0] bwa [NB];
	logic [7:0]    bwd [NB];

	for (genvar k = 0; k < NB; k++) begin : g_bank
		bfp_bank #(
			.DEPTH(NE),
			.AW(AW)
		) u_bank (
			.clk(clk),
			.re(accept),
			.ra(addr0[k]),
			.rd(bank_rd[k]),
			.we(bwe[k]),
			.wa(bwa[k]),
			.wd(bwd[k])
		);
	end

	// last stage 1 write, kept for the item that read in the same cycle
	logic          fwd_we_q [NB];
	logic [AW-1:0] fwd_addr_q [NB];
	logic [7:0]    fwd_data_q [NB];

	// stage 1: merge or extract over an eight byte window
	logic [7:0]  rdf [NB];
	logic [63:0] win, nwin, fmask;
	logic [6:0]  end_s1;
	logic [7:0]  tch;
	logic [31:0] rbits, data_s1;

	always_comb begin
		for (int k = 0; k < NB; k++) begin
			rdf[k] = (fwd_we_q[k] && fwd_addr_q[k] == addr_s1[k]) ? fwd_data_q[k]
				: bank_rd[k];
		end
		for (int j = 0; j < NB; j++) begin
			win[8*j +: 8] = rdf[3'(base3_s1 + 3'(j))];
		end
	end

	assign fmask = 64'(mask_s1) << off_s1;
	assign nwin = (win & ~fmask) | (64'(fv_s1 & mask_s1) << off_s1);
	assign rbits = 32'(win >> off_s1) & mask_s1;
	assign end_s1 = 7'(off_s1) + 7'(w_s1);

	always_comb begin
		for (int j = 0; j < NB; j++) begin
			tch[j] = (w_s1 != 6'd0) && (7'(8 * j) < end_s1);
		end
	end

	always_comb begin
		if (!rd_s1) begin
			data_s1 = '0;
		end else if (sgn_s1) begin
			data_s1 = rbits[0] ? (32'd0 - (rbits >> 1)) : (rbits >> 1);
		end else begin
			data_s1 = rbits;
		end
	end

	always_comb begin
		for (int k = 0; k < NB; k++) begin
			if (clr_busy_q) begin
				bwe[k] = 1'b1;
				bwa[k] = clr_addr_q;
				bwd[k] = 8'd0;
			end else begin
				bwe[k] = s1_adv && wr_s1 && tch[3'(3'(k) - base3_s1)];
				bwa[k] = addr_s1[k];
				bwd[k] = nwin[8*(3'(3'(k) - base3_s1)) +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NB; k++) begin
				fwd_we_q[k] <= 1'b0;
			end
		end else if (s1_adv) begin
			for (int k = 0; k < NB; k++) begin
				fwd_we_q[k] <= bwe[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			for (int k = 0; k < NB; k++) begin
				fwd_addr_q[k] <= bwa[k];
				fwd_data_q[k] <= bwd[k];
			end
		end
	end

	// output register
	logic [31:0] cur_ext, cur_round;

	assign cur_ext = 32'(cur_s1);
	assign cur_round = cur_ext + 32'd7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			read_data <= data_s1;
			bit_position <= cur_ext[14:0];
			byte_position <= cur_round[14:3];
			access_failed <= fail_s1;
			sticky_error <= err_s1;
		end
	end

endmodule

### hw/rtl/bfp_checker.sv
// port-level checks for the bit field packer, bound to the top level
module bfp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] read_data,
	input logic [14:0]        bit_position,
	input logic [11:0]        byte_position,
	input logic               access_failed,
	input logic               sticky_error
);

	logic [15:0] bp_round;

	assign bp_round = {1'b0, bit_position} + 16'd7;

	// a result beat waiting for the sink stays valid and keeps its data, bit position and flags
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data)
			&& $stable(bit_position) && $stable(access_failed) && $stable(sticky_error))
		else $error("result beat changed while stalled");

	// a failed access always leaves the sticky error set
	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && access_failed |-> sticky_error)
		else $error("access failed without sticky error");

	// failed accesses return zero data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && access_failed |-> read_data == 32'sd0)
		else $error("failed access returned data");

	// byte position is the bit position rounded up
	a_byte_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_position == bp_round[14:3])
		else $error("byte position does not match bit position");

endmodule

bind bit_field_packer bfp_checker u_bfp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.read_data(read_data),
	.bit_position(bit_position),
	.byte_position(byte_position),
	.access_failed(access_failed),
	.sticky_error(sticky_error)
);

### verif/bit_field_packer_tb.sv
// self-checking testbench for the bit field packer: directed table, random records, limit phases
`timescale 1ns / 1ps

module bit_field_packer_tb;
	import bfp_pkg::*;

	localparam int unsigned BUF_BYTES = BUFFER_BYTES_DEF;
	localparam int unsigned BIT_SEL_MASK = 7;
	localparam int unsigned DRAIN_CYCLES = 4;

	// codes the block does not decode
	localparam action_t ACT_UNUSED_LO = 3'd6;
	localparam action_t ACT_UNUSED_HI = 3'd7;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] write_value;
		logic [5:0]         bit_count;
		logic [11:0]        seek_byte;
	} packer_cmd_t;

	typedef struct packed {
		logic signed [31:0] read_data;
		logic [14:0]        bit_position;
		logic [11:0]        byte_position;
		logic               access_failed;
		logic               sticky_error;
	} packer_res_t;

	typedef struct packed {
		packer_cmd_t cmd;
		logic        known;
		packer_res_t res;
	} directed_row_t;

	localparam packer_res_t FROM_MODEL = '0;

	localparam directed_row_t DIRECTED_ROWS [28] = '{
		'{'{ACT_READ_U, 32'sd0, 6'd0, 12'd0}, 1'b1, '{32'sd0, 15'd0, 12'd0, 1'b0, 1'b0}},
		'{'{ACT_READ_U, 32'sd0, 6'd32, 12'd0}, 1'b1, '{32'sd0, 15'd32, 12'd4, 1'b0, 1'b0}},
		'{'{ACT_WRITE_U, 32'hFFFFFFFF, 6'd32, 12'd0}, 1'b1,
			'{32'sd0, 15'd64, 12'd8, 1'b0, 1'b0}},
		'{'{ACT_WRITE_U, 32'h80000001, 6'd63, 12'd0}, 1'b0, FROM_MODEL},
		'{'{ACT_WRITE_S, 32'hFFFFFFFF, 6'd0, 12'd0}, 1'b0, FROM_MODEL},
		'{'{ACT_WRITE_S, 32'h80000000, 6'd32, 12'd0}, 1'b0, FROM_MODEL},
		'{'{ACT_WRITE_S, 32'h7FFFFFFF, 6'd32, 12'd0}, 1'b0, FROM_MODEL},
		'{'{ACT_WRITE_S, 32'sd5, 6'd1, 12'd0}, 1'b0, FROM_MODEL},
		'{'{ACT_WRITE_U, 32'h00000055, 6'd7, 12'd0}, 1'b0, FROM_MODEL},
		'{'{ACT_SEEK, 32'sd0, 6'd0, 12'd4}, 1'b1, '{32'sd0, 15'd32, 12'd4, 1'b0, 1'b0}},
		'{'{ACT_READ_U, 32'sd0, 6'd63, 12'd0}, 1'b0, FROM_MODEL},
		'{'{ACT_READ_U, 32'sd0, 6'd32, 12'd0}, 1'b0, FROM_MODEL},
		'{'{ACT_READ_S, 32'sd0, 6'd0, 12'd0}, 1'b0, FROM_MODEL},
		'{'{ACT_READ_S, 32'sd0, 6'd32, 12'd0}, 1'b0, FROM_MODEL},
		'{'{ACT_READ_S, 32'sd0, 6'd32, 12'd0}, 1'b0, FROM_MODEL},
		'{'{ACT_READ_S, 32'sd0, 6'd1, 12'd0}, 1'b0, FROM_MODEL},
		'{'{ACT_READ_U, 32'sd0, 6'd7, 12'd0}, 1'b0, FROM_MODEL},
		// seek past the buffer saturates at its end
		'{'{ACT_SEEK, 32'sd0, 6'd0, 12'hFFF}, 1'b1,
			'{32'sd0, 15'd16384, 12'd2048, 1'b0, 1'b0}},
		'{'{ACT_WRITE_U, 32'sd1, 6'd1, 12'd0}, 1'b1,
			'{32'sd0, 15'd16384, 12'd2048, 1'b1, 1'b1}},
		'{'{ACT_READ_U, 32'sd0, 6'd1, 12'd0}, 1'b1,
			'{32'sd0, 15'd16384, 12'd2048, 1'b1, 1'b1}},
		// both parts fail, failed flag reads as positive
		'{'{ACT_READ_S, 32'sd0, 6'd5, 12'd0}, 1'b1,
			'{32'sd0, 15'd16384, 12'd2048, 1'b1, 1'b1}},
		'{'{ACT_UNUSED_LO, 32'sd0, 6'd0, 12'd0}, 1'b1,
			'{32'sd0, 15'd16384, 12'd2048, 1'b0, 1'b1}},
		'{'{ACT_UNUSED_HI, 32'hFFFFFFFF, 6'd63, 12'hFFF}, 1'b1,
			'{32'sd0, 15'd16384, 12'd2048, 1'b0, 1'b1}},
		'{'{ACT_RESTART, 32'sd0, 6'd0, 12'd0}, 1'b1, '{32'sd0, 15'd0, 12'd0, 1'b0, 1'b0}},
		'{'{ACT_SEEK, 32'sd0, 6'd0, 12'd2047}, 1'b1,
			'{32'sd0, 15'd16376, 12'd2047, 1'b0, 1'b0}},
		// flag fits, magnitude runs past the end
		'{'{ACT_WRITE_S, -32'sd3, 6'd9, 12'd0}, 1'b0, FROM_MODEL},
		'{'{ACT_SEEK, 32'sd0, 6'd0, 12'd2047}, 1'b1,
			'{32'sd0, 15'd16376, 12'd2047, 1'b0, 1'b1}},
		'{'{ACT_READ_S, 32'sd0, 6'd9, 12'd0}, 1'b0, FROM_MODEL}
	};

	localparam int N_PHASES = 8;
	localparam logic [11:0] PH_RD [N_PHASES] = '{12'd0, 12'd4095, 12'd16, 12'd24,
		12'd5, 12'd2048, 12'd1, 12'd2047};
	localparam logic [11:0] PH_WR [N_PHASES] = '{12'd0, 12'd4095, 12'd24, 12'd16,
		12'd2048, 12'd3, 12'd1, 12'd2049};
	localparam int unsigned PH_ITEMS [N_PHASES] = '{40, 150, 120, 120, 100, 100, 60, 150};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	action_t            action = ACT_WRITE_U;
	logic signed [31:0] write_value = '0;
	logic [5:0]         bit_count = '0;
	logic [11:0]        seek_byte = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] read_data;
	logic [14:0]        bit_position;
	logic [11:0]        byte_position;
	logic               access_failed;
	logic               sticky_error;

	bit_field_packer i_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mirror of the block state
	bit [7:0]    shadow_mem [BUF_BYTES];
	int unsigned cursor_bits = 0;
	bit          error_mirror = 1'b0;
	logic [11:0] rd_limit = LIMIT_RESET;
	logic [11:0] wr_limit = LIMIT_RESET;

	packer_res_t pending_results [$];
	packer_res_t want_res;
	int unsigned fail_cnt = 0;
	int unsigned burst_left = 0;

	function automatic int unsigned clamp_limit(logic [11:0] v);
		return (v > BUF_BYTES) ? BUF_BYTES : v;
	endfunction

	function automatic bit put_bits(logic [31:0] value, int unsigned count);
		if (count == 0)
			return 1'b1;
		if (cursor_bits + count > clamp_limit(wr_limit) * 8) begin
			error_mirror = 1'b1;
			return 1'b0;
		end
		for (int i = 0; i < count; i++) begin
			if ((cursor_bits >> 3) < BUF_BYTES)
				shadow_mem[cursor_bits >> 3][cursor_bits & BIT_SEL_MASK] = value[i];
			cursor_bits++;
		end
		return 1'b1;
	endfunction

	function automatic bit get_bits(int unsigned count, output logic [31:0] value);
		int unsigned lim;
		lim = clamp_limit(rd_limit);
		value = '0;
		if (count == 0)
			return 1'b1;
		if (cursor_bits + count > lim * 8) begin
			error_mirror = 1'b1;
			return 1'b0;
		end
		for (int i = 0; i < count; i++) begin
			if ((cursor_bits >> 3) < lim)
				value[i] = shadow_mem[cursor_bits >> 3][cursor_bits & BIT_SEL_MASK];
			cursor_bits++;
		end
		return 1'b1;
	endfunction

	function automatic packer_res_t apply_action(packer_cmd_t c);
		packer_res_t r;
		int unsigned cnt, mcnt, skb;
		logic [31:0] data, flag, mag, uval;
		bit ok, ok_flag, ok_mag;
		cnt = (c.bit_count > MAX_FIELD) ? MAX_FIELD : c.bit_count;
		mcnt = (cnt > 0) ? cnt - 1 : 0;
		data = '0;
		ok = 1'b1;
		uval = c.write_value;
		case (c.action)
			ACT_WRITE_U: ok = put_bits(uval, cnt);
			ACT_READ_U: ok = get_bits(cnt, data);
			ACT_WRITE_S: begin
				mag = uval[31] ? (32'd0 - uval) : uval;
				ok_flag = put_bits({31'd0, uval[31]}, 1);
				ok_mag = put_bits(mag, mcnt);
				ok = ok_flag && ok_mag;
			end
			ACT_READ_S: begin
				ok_flag = get_bits(1, flag);
				ok_mag = get_bits(mcnt, mag);
				data = flag[0] ? (32'd0 - mag) : mag;
				ok = ok_flag && ok_mag;
			end
			ACT_SEEK: begin
				skb = (c.seek_byte > BUF_BYTES) ? BUF_BYTES : c.seek_byte;
				cursor_bits = skb * 8;
			end
			ACT_RESTART: begin
				cursor_bits = 0;
				error_mirror = 1'b0;
			end
			default: ;
		endcase
		r.read_data = data;
		r.bit_position = 15'(cursor_bits);
		r.byte_position = 12'((cursor_bits + 7) >> 3);
		r.access_failed = !ok;
		r.sticky_error = error_mirror;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, name, want, got);
			fail_cnt++;
		end
	endfunction

	function automatic packer_cmd_t mk_cmd(action_t a, logic [31:0] v, logic [5:0] n,
		logic [11:0] s);
		packer_cmd_t c;
		c.action = a;
		c.write_value = v;
		c.bit_count = n;
		c.seek_byte = s;
		return c;
	endfunction

	function automatic logic [5:0] pick_width();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 2)
			return 6'd0;
		if (r < 4)
			return 6'd32;
		if (r == 4)
			return 6'($urandom_range(33, 63));
		if (r < 7)
			return 6'd1;
		return 6'($urandom_range(1, 31));
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 15))
			0: return 32'h80000000;
			1: return 32'h7FFFFFFF;
			2: return 32'h00000000;
			3: return 32'hFFFFFFFF;
			4: return 32'($urandom_range(0, 255));
			5: return 32'd0 - 32'($urandom_range(1, 255));
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(packer_cmd_t c, bit known, packer_res_t known_res);
		packer_res_t pred;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		action <= c.action;
		write_value <= c.write_value;
		bit_count <= c.bit_count;
		seek_byte <= c.seek_byte;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		pred = apply_action(c);
		pending_results.push_back(known ? known_res : pred);
	endtask

	task automatic wait_results_done();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_xfer(bit wr, reg_idx_t idx, logic [31:0] wdata,
		output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_limits(logic [11:0] rd, logic [11:0] wr);
		logic [31:0] rdata;
		apb_xfer(1'b1, REG_READ_LIMIT, {20'd0, rd}, rdata);
		rd_limit = rd;
		apb_xfer(1'b1, REG_WRITE_LIMIT, {20'd0, wr}, rdata);
		wr_limit = wr;
		apb_xfer(1'b0, REG_READ_LIMIT, '0, rdata);
		check_field("read_limit_bytes readback", {20'd0, rd_limit}, rdata);
		apb_xfer(1'b0, REG_WRITE_LIMIT, '0, rdata);
		check_field("write_limit_bytes readback", {20'd0, wr_limit}, rdata);
	endtask

	// mostly write-then-read-back records at a seek point, with some noise mixed in
	task automatic run_random(int unsigned target);
		int unsigned sent, k, base, lim;
		bit          sgn [8];
		logic [5:0]  wid [8];
		sent = 0;
		while (sent < target) begin
			case ($urandom_range(0, 9))
				0: begin
					if ($urandom_range(0, 1))
						send_item(mk_cmd(ACT_RESTART, $urandom, 6'($urandom), 12'($urandom)),
							1'b0, FROM_MODEL);
					else
						send_item(mk_cmd(ACT_SEEK, $urandom, 6'($urandom), 12'($urandom)),
							1'b0, FROM_MODEL);
					sent++;
				end
				1, 2: begin
					send_item(mk_cmd(action_t'($urandom_range(0, 7)), pick_value(),
						6'($urandom), 12'($urandom)), 1'b0, FROM_MODEL);
					sent++;
				end
				default: begin
					lim = clamp_limit(wr_limit);
					case ($urandom_range(0, 3))
						0, 1: base = $urandom_range(0, (lim < 40) ? lim : 40);
						2: base = lim - $urandom_range(0, (lim < 6) ? lim : 6);
						default: base = $urandom_range(0, BUF_BYTES);
					endcase
					k = $urandom_range(1, 6);
					send_item(mk_cmd(ACT_SEEK, $urandom, 6'($urandom), 12'(base)),
						1'b0, FROM_MODEL);
					for (int i = 0; i < k; i++) begin
						sgn[i] = $urandom_range(0, 1);
						wid[i] = pick_width();
						send_item(mk_cmd(sgn[i] ? ACT_WRITE_S : ACT_WRITE_U, pick_value(),
							wid[i], 12'($urandom)), 1'b0, FROM_MODEL);
					end
					send_item(mk_cmd(ACT_SEEK, $urandom, 6'($urandom), 12'(base)),
						1'b0, FROM_MODEL);
					for (int i = 0; i < k; i++) begin
						// occasionally read back with the wrong width
						if ($urandom_range(0, 9) == 0)
							wid[i] = pick_width();
						send_item(mk_cmd(sgn[i] ? ACT_READ_S : ACT_READ_U, $urandom,
							wid[i], 12'($urandom)), 1'b0, FROM_MODEL);
					end
					sent += 2 * k + 2;
				end
			endcase
			if ($urandom_range(0, 99) == 0)
				wait_results_done();
		end
	endtask

	// receiver stalls follow a rotating pattern, reloaded now and then
	logic [15:0] rx_pattern = 16'hFFFF;
	int unsigned rx_cycle = 0;

	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 128 == 0)
			rx_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
		else
			rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
		out_ready <= rx_pattern[0];
	end

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing pending, read_data 0x%08h bit_position %0d",
					$time, read_data, bit_position);
				fail_cnt++;
			end else begin
				want_res = pending_results.pop_front();
				check_field("read_data", want_res.read_data, read_data);
				check_field("bit_position", 32'(want_res.bit_position), 32'(bit_position));
				check_field("byte_position", 32'(want_res.byte_position), 32'(byte_position));
				check_field("access_failed", 32'(want_res.access_failed), 32'(access_failed));
				check_field("sticky_error", 32'(want_res.sticky_error), 32'(sticky_error));
			end
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		foreach (DIRECTED_ROWS[i])
			send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].res);
		run_random(200);
		for (int p = 0; p < N_PHASES; p++) begin
			wait_results_done();
			set_limits(PH_RD[p], PH_WR[p]);
			run_random(PH_ITEMS[p]);
		end
		wait_results_done();
		if (fail_cnt == 0)
			$display("bit_field_packer_tb: PASS");
		else
			$display("bit_field_packer_tb: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("bit_field_packer_tb: FAIL");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/bfp_pkg.sv
hw/rtl/bfp_bank.sv
hw/rtl/bit_field_packer.sv
hw/rtl/bfp_checker.sv
verif/bit_field_packer_tb.sv
